[sv/mzg_pkg.sv]
// shared types, state codes and helper functions of the maze generator
package mzg_pkg;

  // one search frame: cell coordinates, shuffled directions and loop position
  typedef struct packed {
    logic [7:0]      x;
    logic [7:0]      y;
    logic [3:0][1:0] order;
    logic [2:0]      pos;
  } frame_t;

  // direction codes
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XM = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  // command codes
  localparam logic CMD_GEN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  // register byte offset bit that selects the register slot
  localparam logic REG_SEED = 1'b0;

  // identity direction order
  localparam logic [3:0][1:0] ORDER_INIT = {DIR_YM, DIR_YP, DIR_XM, DIR_XP};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_OPEN_START,
    ST_SHUF_RNG,
    ST_SHUF_SWAP,
    ST_LOOP,
    ST_PROBE,
    ST_OPEN_NEXT,
    ST_OPEN_MID,
    ST_POP_LOAD,
    ST_OPEN_EXIT
  } ctl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd_cell;
    logic res_read;
    logic res_err;
    logic res_gen;
    logic fill_step;
    logic open_start;
    logic rng_step;
    logic swap_apply;
    logic loop_step;
    logic open_next;
    logic open_mid;
    logic pop_issue;
    logic pop_load;
    logic open_exit;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_ok;
    logic fill_last;
    logic shuf_last;
    logic pos_done;
    logic depth_one;
    logic nb_interior;
    logic probe_wall;
  } dp_stat_t;

  // xorshift32 step
  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // remainder by three: base-4 digits each weigh one modulo three
  function automatic logic [1:0] mod3(input logic [31:0] v);
    logic [5:0] s;
    logic [3:0] t;
    s = '0;
    for (int k = 0; k < 16; k++) begin
      s = s + 6'(v[2*k +: 2]);
    end
    t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    if (t >= 4'd6) t = t - 4'd6;
    else if (t >= 4'd3) t = t - 4'd3;
    return t[1:0];
  endfunction

endpackage

[sv/mzg_ctrl.sv]
// sequencing state machine of the maze generator
module mzg_ctrl import mzg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_command,
  input  dp_stat_t   stat,
  output ctl_cmd_t   cmd,
  output logic       busy
);

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && stat.in_ok) begin
          state_nxt = (in_command == CMD_READ) ? ST_READ : ST_FILL;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_FILL: if (stat.fill_last) state_nxt = ST_OPEN_START;
      ST_OPEN_START: state_nxt = ST_SHUF_RNG;
      ST_SHUF_RNG: state_nxt = ST_SHUF_SWAP;
      ST_SHUF_SWAP: state_nxt = stat.shuf_last ? ST_LOOP : ST_SHUF_RNG;
      ST_LOOP: begin
        if (stat.pos_done) state_nxt = stat.depth_one ? ST_OPEN_EXIT : ST_POP_LOAD;
        else if (stat.nb_interior) state_nxt = ST_PROBE;
      end
      ST_PROBE: state_nxt = stat.probe_wall ? ST_OPEN_NEXT : ST_LOOP;
      ST_OPEN_NEXT: state_nxt = ST_OPEN_MID;
      ST_OPEN_MID: state_nxt = ST_SHUF_RNG;
      ST_POP_LOAD: state_nxt = ST_LOOP;
      ST_OPEN_EXIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = stat.in_ok;
          cmd.rd_cell = stat.in_ok && (in_command == CMD_READ);
          cmd.res_err = !stat.in_ok;
        end
      end
      ST_READ:       cmd.res_read = 1'b1;
      ST_FILL:       cmd.fill_step = 1'b1;
      ST_OPEN_START: cmd.open_start = 1'b1;
      ST_SHUF_RNG:   cmd.rng_step = 1'b1;
      ST_SHUF_SWAP:  cmd.swap_apply = 1'b1;
      ST_LOOP: begin
        cmd.loop_step = !stat.pos_done;
        cmd.pop_issue = stat.pos_done && !stat.depth_one;
      end
      ST_PROBE:      ;
      ST_OPEN_NEXT:  cmd.open_next = 1'b1;
      ST_OPEN_MID:   cmd.open_mid = 1'b1;
      ST_POP_LOAD:   cmd.pop_load = 1'b1;
      ST_OPEN_EXIT: begin
        cmd.open_exit = 1'b1;
        cmd.res_gen = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[sv/mzg_dpath.sv]
// grid memory, search stack, random generator and result registers
module mzg_dpath import mzg_pkg::*; #(
  parameter int GRID_WIDTH  = 31,
  parameter int GRID_HEIGHT = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  input  logic        in_command,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_exit_col,
  input  logic [7:0]  in_exit_row,
  input  logic [31:0] seed,
  output logic        out_strobe,
  output logic        out_cell_value,
  output logic        out_status
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int SLOTS = ((GRID_WIDTH - 1) / 2) * ((GRID_HEIGHT - 1) / 2) + 1;
  localparam int SAW   = $clog2(SLOTS);
  localparam int DW    = $clog2(SLOTS + 1);

  logic             grid_mem [CELLS];
  frame_t           stack_mem [SLOTS];
  logic             grid_rd_r;
  frame_t           stack_rd_r;

  logic [7:0]       start_x_r, start_y_r, exit_x_r, exit_y_r;
  logic [AW-1:0]    fill_r;
  logic [31:0]      rnd_r;
  frame_t           cur_r;
  logic [DW-1:0]    depth_r;
  logic [1:0]       shuf_i_r;
  logic [7:0]       nb_x_r, nb_y_r, mid_x_r, mid_y_r;
  logic             grid_init_r;
  logic             out_strobe_r, out_cell_r, out_status_r;

  logic             g_we;
  logic [AW-1:0]    g_wa, g_ra;
  logic [1:0]       dir;
  logic signed [9:0] sx, sy, nx, ny, mx, my;
  logic [1:0]       swap_j;
  logic [3:0][1:0]  ord_sw;

  function automatic logic [AW-1:0] addr(input logic [7:0] x, input logic [7:0] y);
    return AW'(y) * AW'(GRID_WIDTH) + AW'(x);
  endfunction

  // range check of the incoming item
  always_comb begin
    stat.in_ok = (in_col < 8'(GRID_WIDTH)) && (in_row < 8'(GRID_HEIGHT));
    if (in_command == CMD_GEN) begin
      stat.in_ok = stat.in_ok && (in_exit_col < 8'(GRID_WIDTH))
                   && (in_exit_row < 8'(GRID_HEIGHT));
    end
  end

  // neighbor two cells away and the wall cell between
  always_comb begin
    dir = cur_r.order[cur_r.pos[1:0]];
    sx = 10'(cur_r.x);
    sy = 10'(cur_r.y);
    nx = sx;
    ny = sy;
    mx = sx;
    my = sy;
    case (dir)
      DIR_XP: begin nx = sx + 10'sd2; mx = sx + 10'sd1; end
      DIR_XM: begin nx = sx - 10'sd2; mx = sx - 10'sd1; end
      DIR_YP: begin ny = sy + 10'sd2; my = sy + 10'sd1; end
      default: begin ny = sy - 10'sd2; my = sy - 10'sd1; end
    endcase
    stat.nb_interior = (nx > 10'sd0) && (nx < 10'(GRID_WIDTH - 1))
                       && (ny > 10'sd0) && (ny < 10'(GRID_HEIGHT - 1));
  end

  assign stat.fill_last  = (fill_r == AW'(CELLS - 1));
  assign stat.shuf_last  = (shuf_i_r == 2'd1);
  assign stat.pos_done   = cur_r.pos[2];
  assign stat.depth_one  = (depth_r == DW'(1));
  assign stat.probe_wall = grid_rd_r;

  // grid port selection
  always_comb begin
    g_we = 1'b1;
    g_wa = fill_r;
    if (cmd.open_start) g_wa = addr(start_x_r, start_y_r);
    else if (cmd.open_next) g_wa = addr(nb_x_r, nb_y_r);
    else if (cmd.open_mid) g_wa = addr(mid_x_r, mid_y_r);
    else if (cmd.open_exit) g_wa = addr(exit_x_r, exit_y_r);
    else if (!cmd.fill_step) g_we = 1'b0;
    g_ra = cmd.rd_cell ? addr(in_col, in_row) : addr(nx[7:0], ny[7:0]);
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_wa] <= cmd.fill_step;
    grid_rd_r <= grid_mem[g_ra];
  end

  // search stack memory: holds the frames below the current one
  always_ff @(posedge clk) begin
    if (cmd.open_mid) stack_mem[SAW'(depth_r - DW'(1))] <= cur_r;
    stack_rd_r <= stack_mem[SAW'(depth_r - DW'(2))];
  end

  // fisher-yates swap partner
  always_comb begin
    case (shuf_i_r)
      2'd3:    swap_j = rnd_r[1:0];
      2'd2:    swap_j = mod3(rnd_r);
      default: swap_j = {1'b0, rnd_r[0]};
    endcase
    ord_sw = cur_r.order;
    ord_sw[shuf_i_r] = cur_r.order[swap_j];
    ord_sw[swap_j] = cur_r.order[shuf_i_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r        <= 32'd1;
      depth_r      <= '0;
      grid_init_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.res_read || cmd.res_err || cmd.res_gen;
      if (cmd.load_in && in_command == CMD_GEN) begin
        rnd_r       <= seed;
        grid_init_r <= 1'b1;
      end
      if (cmd.rng_step) rnd_r <= xorshift(rnd_r);
      if (cmd.open_start) depth_r <= DW'(1);
      if (cmd.open_mid) depth_r <= depth_r + DW'(1);
      if (cmd.pop_issue) depth_r <= depth_r - DW'(1);
    end
  end

  // frame and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      start_x_r <= in_col;
      start_y_r <= in_row;
      exit_x_r  <= in_exit_col;
      exit_y_r  <= in_exit_row;
      fill_r    <= '0;
    end
    if (cmd.fill_step) fill_r <= fill_r + AW'(1);
    if (cmd.open_start) begin
      cur_r    <= '{x: start_x_r, y: start_y_r, order: ORDER_INIT, pos: 3'd0};
      shuf_i_r <= 2'd3;
    end
    if (cmd.swap_apply) begin
      cur_r.order <= ord_sw;
      shuf_i_r    <= shuf_i_r - 2'd1;
    end
    if (cmd.loop_step) begin
      cur_r.pos <= cur_r.pos + 3'd1;
      nb_x_r    <= nx[7:0];
      nb_y_r    <= ny[7:0];
      mid_x_r   <= mx[7:0];
      mid_y_r   <= my[7:0];
    end
    if (cmd.open_mid) begin
      cur_r    <= '{x: nb_x_r, y: nb_y_r, order: ORDER_INIT, pos: 3'd0};
      shuf_i_r <= 2'd3;
    end
    if (cmd.pop_load) cur_r <= stack_rd_r;
  end

  // result registers
  always_ff @(posedge clk) begin
    out_cell_r   <= cmd.res_read && (grid_rd_r || !grid_init_r);
    out_status_r <= cmd.res_err ? STAT_ERR : STAT_OK;
  end

  assign out_strobe     = out_strobe_r;
  assign out_cell_value = out_cell_r;
  assign out_status     = out_status_r;

endmodule

[sv/maze_generator_dfs_unit.sv]
// top level of the maze generator: configuration port, controller and datapath
// Maze generator by randomized depth-first search on a GRID_WIDTH x GRID_HEIGHT
// grid. Drive start with an item while busy is low; exactly one result comes back
// on out_strobe for one cycle and cannot be stalled. A read registers the grid
// memory word and then the result; a command with coordinates outside the grid
// answers status 1 in the next cycle. A generate first sweeps the grid memory, one
// cell a cycle, then walks the search: each visited cell shuffles its directions
// in alternating random-step and swap states, each direction tried passes the loop
// state and, for an interior neighbour, a probe of the grid, a carve opens the
// neighbour and then the wall between, and a backtrack issues the stack read and
// then loads the popped frame. The seed register is taken when a generate starts.
module maze_generator_dfs_unit import mzg_pkg::*; #(
  parameter int GRID_WIDTH  = 31,
  parameter int GRID_HEIGHT = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_exit_col,
  input  logic [7:0]  in_exit_row,
  output logic        out_strobe,
  output logic        out_cell_value,
  output logic        out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] seed_r;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= 32'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_SEED) begin
      seed_r <= cfg_pwdata;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED) ? seed_r : 32'd0;

  mzg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start && !busy),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  mzg_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_command),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_exit_col    (in_exit_col),
    .in_exit_row    (in_exit_row),
    .seed           (seed_r),
    .out_strobe     (out_strobe),
    .out_cell_value (out_cell_value),
    .out_status     (out_status)
  );

`ifndef SYNTHESIS
  // a result only shows once the block has gone back to idle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");

  // an error result never carries a wall bit
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> !out_cell_value) else $error("error with cell value");

  // an accepted item either answers at once or keeps the block busy
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe)) else $error("item dropped");
`endif

endmodule
